FILE: hdl/bfrr_pkg.sv
// Shared constants and types for the band filter round robin router.
`default_nettype none

package bfrr_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned DEST_W = 4;
  localparam int unsigned CFG_IDX_W = 3;

  // Default record buffer depth.
  localparam int unsigned MAX_RECORD_WORDS = 8;

  // Largest number of round robin destinations; the destination field caps it at 16.
  localparam int unsigned MAX_OUTPUTS = 16;
  localparam int unsigned OUT_LIMIT = (MAX_OUTPUTS < 16) ? MAX_OUTPUTS : 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_WORDS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_POSITION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BOUND  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_BOUND  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 3'd4;

  // Emitter status seen by the capture side.
  typedef struct packed {
    logic busy;  // a record is held for emission
    logic done;  // its final word leaves the buffer this cycle
  } emit_status_t;

endpackage

`default_nettype wire

FILE: hdl/bfrr_emit.sv
// Emit buffer and output register that replay one passing record word by word.
`default_nettype none

module bfrr_emit #(
  parameter int unsigned MaxRecordWords = bfrr_pkg::MAX_RECORD_WORDS,
  localparam int unsigned IdxW = (MaxRecordWords > 1) ? $clog2(MaxRecordWords) : 1,
  localparam int unsigned LenW = $clog2(MaxRecordWords + 1)
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  // Record hand-over from the capture side.
  input  wire logic                                         load_valid_i,
  input  wire logic [LenW-1:0]                              load_len_i,
  input  wire logic [bfrr_pkg::DEST_W-1:0]                  load_dest_i,
  input  wire logic [MaxRecordWords-1:0][bfrr_pkg::DATA_W-1:0] load_words_i,
  output bfrr_pkg::emit_status_t                            status_o,
  // Result stream.
  output logic                                              m_axis_tvalid,
  input  wire logic                                         m_axis_tready,
  output logic [bfrr_pkg::DATA_W-1:0]                       m_axis_tdata,  // out_word
  output logic [bfrr_pkg::DEST_W-1:0]                       m_axis_tuser,  // destination
  output logic                                              m_axis_tlast   // last_word
);
  import bfrr_pkg::*;

  logic [DATA_W-1:0] emit_buf_q [MaxRecordWords];
  logic              emit_busy_q;
  logic [IdxW-1:0]   emit_idx_q;
  logic [LenW-1:0]   emit_len_q;
  logic [DEST_W-1:0] emit_dest_q;

  logic              out_valid_q;
  logic [DATA_W-1:0] out_data_q;
  logic [DEST_W-1:0] out_dest_q;
  logic              out_last_q;

  logic out_free;
  logic push;
  logic last_push;

  // A word moves into the output register when it is empty or being taken.
  assign out_free  = !out_valid_q || m_axis_tready;
  assign push      = emit_busy_q && out_free;
  assign last_push = push && ((LenW'(emit_idx_q) + LenW'(1)) == emit_len_q);

  assign status_o.busy = emit_busy_q;
  assign status_o.done = last_push;

  // Record storage for replay; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_valid_i) begin
      for (int i = 0; i < int'(MaxRecordWords); i++) begin
        emit_buf_q[i] <= load_words_i[i];
      end
      emit_len_q  <= load_len_i;
      emit_dest_q <= load_dest_i;
    end
  end

  // Replay sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_busy_q <= 1'b0;
      emit_idx_q  <= '0;
    end else if (load_valid_i) begin
      emit_busy_q <= 1'b1;
      emit_idx_q  <= '0;
    end else if (last_push) begin
      emit_busy_q <= 1'b0;
      emit_idx_q  <= '0;
    end else if (push) begin
      emit_idx_q <= emit_idx_q + IdxW'(1);
    end
  end

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (push) begin
      out_data_q <= emit_buf_q[emit_idx_q];
      out_dest_q <= emit_dest_q;
      out_last_q <= last_push;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_dest_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

FILE: hdl/band_filter_round_robin_router.sv
// Top level of the band filter round robin router: record capture, key test and routing.
//
//  Channel  Direction  Handshake                     Payload
//  s_axis   in         s_axis_tvalid/s_axis_tready   tdata[31:0] word
//  m_axis   out        m_axis_tvalid/m_axis_tready   tdata[31:0] out_word, tuser[3:0]
//                                                    destination, tlast last_word
//  cfg      in         cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// One input word is taken per cycle. A passing record is copied into the emit
// buffer on its last word and leaves one word per cycle unless output backpressure
// holds it, while the next record is being captured. The input stalls only on the
// last word of a record while the previous record is still being replayed. Output
// backpressure holds the output register; configuration writes are always taken.
// Reset clears control state and loads the register reset values.
`default_nettype none

module band_filter_round_robin_router #(
  parameter int unsigned MaxRecordWords = bfrr_pkg::MAX_RECORD_WORDS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration writes.
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [bfrr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bfrr_pkg::DATA_W-1:0]     cfg_data_i,
  // Word stream in.
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [bfrr_pkg::DATA_W-1:0]     s_axis_tdata,  // word
  // Routed records out.
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [bfrr_pkg::DATA_W-1:0]          m_axis_tdata,  // out_word
  output logic [bfrr_pkg::DEST_W-1:0]          m_axis_tuser,  // destination
  output logic                                 m_axis_tlast   // last_word
);
  import bfrr_pkg::*;

  localparam int unsigned IdxW = (MaxRecordWords > 1) ? $clog2(MaxRecordWords) : 1;
  localparam int unsigned LenW = $clog2(MaxRecordWords + 1);

  // Configuration registers.
  logic [3:0]               record_words_q;
  logic [2:0]               key_position_q;
  logic signed [DATA_W-1:0] lower_bound_q;
  logic signed [DATA_W-1:0] upper_bound_q;
  logic [4:0]               output_count_q;

  // Capture state.
  logic [DATA_W-1:0] cap_q [MaxRecordWords];
  logic [IdxW-1:0]   word_index_q;
  logic [DEST_W-1:0] next_dest_q;

  logic                                   cfg_write;
  logic                                   len_write;
  logic                                   accept;
  logic [LenW-1:0]                        eff_len;
  logic [4:0]                             eff_outs;
  logic [IdxW-1:0]                        idx_eff;
  logic                                   rec_end;
  logic [IdxW-1:0]                        key_idx;
  logic                                   key_in_record;
  logic signed [DATA_W-1:0]               key_word;
  logic                                   in_band;
  logic                                   load_valid;
  logic [DEST_W-1:0]                      dest_now;
  logic [4:0]                             dest_inc;
  logic [DEST_W-1:0]                      dest_after;
  logic [MaxRecordWords-1:0][DATA_W-1:0]  load_words;
  emit_status_t                           emit_status;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign len_write   = cfg_write && (cfg_index_i == CFG_RECORD_WORDS);

  // Register file writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      record_words_q <= 4'd3;
      key_position_q <= 3'd0;
      lower_bound_q  <= {1'b1, {(DATA_W-1){1'b0}}};
      upper_bound_q  <= {1'b0, {(DATA_W-1){1'b1}}};
      output_count_q <= 5'd1;
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        CFG_RECORD_WORDS: record_words_q <= cfg_data_i[3:0];
        CFG_KEY_POSITION: key_position_q <= cfg_data_i[2:0];
        CFG_LOWER_BOUND:  lower_bound_q  <= cfg_data_i;
        CFG_UPPER_BOUND:  upper_bound_q  <= cfg_data_i;
        CFG_OUTPUT_COUNT: output_count_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Effective record length and destination count after clamping.
  always_comb begin
    if (record_words_q == 4'd0) begin
      eff_len = LenW'(1);
    end else if (32'(record_words_q) > 32'(MaxRecordWords)) begin
      eff_len = LenW'(MaxRecordWords);
    end else begin
      eff_len = LenW'(record_words_q);
    end
    if (output_count_q == 5'd0) begin
      eff_outs = 5'd1;
    end else if (32'(output_count_q) > 32'(OUT_LIMIT)) begin
      eff_outs = 5'(OUT_LIMIT);
    end else begin
      eff_outs = output_count_q;
    end
  end

  // Position of the incoming word and end-of-record detection.
  assign idx_eff = (LenW'(word_index_q) >= eff_len) ? '0 : word_index_q;
  assign rec_end = (LenW'(idx_eff) + LenW'(1)) == eff_len;

  // The last word of a record waits while the previous record is still replayed.
  assign s_axis_tready = !(rec_end && emit_status.busy && !emit_status.done);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Key test; the key may be the word arriving right now.
  assign key_idx       = IdxW'(key_position_q);
  assign key_in_record = 32'(key_position_q) < 32'(eff_len);
  assign key_word      = (key_idx == idx_eff) ? s_axis_tdata : cap_q[key_idx];
  assign in_band       = (lower_bound_q < key_word) && (key_word < upper_bound_q);
  assign load_valid    = accept && rec_end && key_in_record && in_band;

  // Round robin destination, restarting when the count was lowered.
  assign dest_now   = ({1'b0, next_dest_q} >= eff_outs) ? '0 : next_dest_q;
  assign dest_inc   = {1'b0, dest_now} + 5'd1;
  assign dest_after = (dest_inc >= eff_outs) ? '0 : dest_inc[DEST_W-1:0];

  // Record image handed to the emitter, including the word arriving now.
  always_comb begin
    for (int i = 0; i < int'(MaxRecordWords); i++) begin
      load_words[i] = (IdxW'(i) == idx_eff) ? s_axis_tdata : cap_q[i];
    end
  end

  // Capture buffer; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cap_q[idx_eff] <= s_axis_tdata;
    end
  end

  // Word position and destination counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_index_q <= '0;
      next_dest_q  <= '0;
    end else begin
      if (len_write || (accept && rec_end)) begin
        word_index_q <= '0;
      end else if (accept) begin
        word_index_q <= idx_eff + IdxW'(1);
      end
      if (load_valid) begin
        next_dest_q <= dest_after;
      end
    end
  end

  bfrr_emit #(
    .MaxRecordWords(MaxRecordWords)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (load_valid),
    .load_len_i   (eff_len),
    .load_dest_i  (dest_now),
    .load_words_i (load_words),
    .status_o     (emit_status),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // A new record never overwrites one that is still being replayed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_valid |-> (!emit_status.busy || emit_status.done))
    else $error("record loaded over a busy emit buffer");

  // The word position always stays inside the current record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    LenW'(word_index_q) < eff_len)
    else $error("word position beyond record length");

  // A record length write restarts the record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_write |=> (word_index_q == '0))
    else $error("record length write did not restart the record");

  // The destination counter moves only for a passing record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load_valid |=> $stable(next_dest_q))
    else $error("destination advanced without a passing record");

endmodule

`default_nettype wire
